// ===== rtl/tilt_angle_moving_average_macros.svh =====
// assertion macros used by the rtl top level
`ifndef TILT_ANGLE_MOVING_AVERAGE_MACROS_SVH
`define TILT_ANGLE_MOVING_AVERAGE_MACROS_SVH

// same-cycle implication, checked out of reset
`define TAM_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tam check failed");

// next-cycle implication, checked out of reset
`define TAM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tam check failed");

`endif

// ===== rtl/tam_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tam_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int SQ_W           = 32;
    localparam int ROOT_W         = 16;
    localparam int OPND_W         = 17;
    localparam int XY_W           = 34;
    localparam int ANGLE_W        = 26;
    localparam int CORDIC_STEPS   = 20;
    localparam int STEP_W         = 5;
    localparam int PRESCALE_SHIFT = 14;
    localparam int ROUND_SHIFT    = 9;
    localparam int LIMIT_W        = 16;

    localparam logic signed [ANGLE_W-1:0] DEG90       = 26'sd5898240;
    localparam logic [LIMIT_W-1:0]        PITCH_LIMIT = 16'd11520;
    localparam logic [LIMIT_W-1:0]        ROLL_LIMIT  = 16'd23040;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_ANGLE_WAIT,
        ST_UPDATE,
        ST_DIVIDE_WAIT,
        ST_DONE
    } tam_state_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [STEP_W-1:0] step);
        logic signed [ANGLE_W-1:0] v;
        begin
            unique case (step)
                5'd0:    v = 26'sd2949120;
                5'd1:    v = 26'sd1740967;
                5'd2:    v = 26'sd919879;
                5'd3:    v = 26'sd466945;
                5'd4:    v = 26'sd234379;
                5'd5:    v = 26'sd117304;
                5'd6:    v = 26'sd58666;
                5'd7:    v = 26'sd29335;
                5'd8:    v = 26'sd14668;
                5'd9:    v = 26'sd7334;
                5'd10:   v = 26'sd3667;
                5'd11:   v = 26'sd1833;
                5'd12:   v = 26'sd917;
                5'd13:   v = 26'sd458;
                5'd14:   v = 26'sd229;
                5'd15:   v = 26'sd115;
                5'd16:   v = 26'sd57;
                5'd17:   v = 26'sd29;
                5'd18:   v = 26'sd14;
                5'd19:   v = 26'sd7;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tam_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface tam_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source(output valid, output accel_x, output accel_y, output accel_z, input ready);
    modport sink(input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface tam_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] pitch_now;
    logic signed [15:0] roll_now;
    logic signed [14:0] pitch_mean;
    logic signed [15:0] roll_mean;

    modport source(output valid, output pitch_now, output roll_now, output pitch_mean,
                   output roll_mean, input ready);
    modport sink(input valid, input pitch_now, input roll_now, input pitch_mean,
                 input roll_mean, output ready);
endinterface
`default_nettype wire

// ===== rtl/tam_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tam_isqrt
    import tam_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SQ_W-1:0]   radicand,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);
    localparam int REM_W = ROOT_W + 2;

    logic [SQ_W-1:0]   rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;

    // one result bit per cycle
    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = STEP_W'(cnt_reg + 1'b1);
            if (cnt_reg == STEP_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

// ===== rtl/tam_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tam_cordic
    import tam_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [OPND_W-1:0] num,
    input  wire logic signed [OPND_W-1:0] den,
    input  wire logic [LIMIT_W-1:0]       limit,
    output logic                          done,
    output logic signed [15:0]            angle
);
    logic signed [XY_W-1:0]    x_reg, x_next, y_reg, y_next;
    logic signed [XY_W-1:0]    xs, ys, x_init, y_init;
    logic signed [ANGLE_W-1:0] acc_reg, acc_next, acc_init;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic                      zero_reg, zero_next;
    logic [ANGLE_W-1:0]        mag;
    logic [ANGLE_W-ROUND_SHIFT:0] q;
    logic [15:0]               qc;

    // quadrant fold so the vector starts in the right half plane
    always_comb
    begin
        if (den < 0)
        begin
            if (num >= 0)
            begin
                x_init   = XY_W'(num) <<< PRESCALE_SHIFT;
                y_init   = (-XY_W'(den)) <<< PRESCALE_SHIFT;
                acc_init = DEG90;
            end
            else
            begin
                x_init   = (-XY_W'(num)) <<< PRESCALE_SHIFT;
                y_init   = XY_W'(den) <<< PRESCALE_SHIFT;
                acc_init = -DEG90;
            end
        end
        else
        begin
            x_init   = XY_W'(den) <<< PRESCALE_SHIFT;
            y_init   = XY_W'(num) <<< PRESCALE_SHIFT;
            acc_init = '0;
        end
    end

    always_comb
    begin
        xs        = x_reg >>> step_reg;
        ys        = y_reg >>> step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = x_init;
            y_next    = y_init;
            acc_next  = acc_init;
            step_next = '0;
            busy_next = 1'b1;
            zero_next = (num == 0) && (den == 0);
        end
        else if (busy_reg)
        begin
            if (!y_reg[XY_W-1])
            begin
                x_next   = x_reg + ys;
                y_next   = y_reg - xs;
                acc_next = acc_reg + atan_entry(step_reg);
            end
            else
            begin
                x_next   = x_reg - ys;
                y_next   = y_reg + xs;
                acc_next = acc_reg - atan_entry(step_reg);
            end
            step_next = STEP_W'(step_reg + 1'b1);
            if (step_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        zero_reg <= zero_next;
    end

    // 1/65536 degree down to 1/128, half away from zero, then clamp
    always_comb
    begin
        mag = acc_reg[ANGLE_W-1] ? ANGLE_W'(-acc_reg) : ANGLE_W'(acc_reg);
        q   = (ANGLE_W-ROUND_SHIFT+1)'(({1'b0, mag} + (ANGLE_W+1)'(256)) >> ROUND_SHIFT);
        qc  = (q > (ANGLE_W-ROUND_SHIFT+1)'(limit)) ? limit : 16'(q);
        if (zero_reg)
            angle = '0;
        else if (acc_reg[ANGLE_W-1])
            angle = -$signed(qc);
        else
            angle = $signed(qc);
    end

    assign done = done_reg;
endmodule
`default_nettype wire

// ===== rtl/tam_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tam_divider
    import tam_pkg::*;
#(
    parameter int SUM_W = 21,
    parameter int CNT_W = 5
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [SUM_W-1:0] total,
    input  wire logic [CNT_W-1:0]        count,
    output logic                         done,
    output logic signed [15:0]           mean
);
    localparam int N     = SUM_W + 1;
    localparam int ITR_W = $clog2(N + 1);

    logic [N-1:0]     dvd_reg, dvd_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] dvs_reg, dvs_next;
    logic [ITR_W-1:0] itr_reg, itr_next;
    logic             neg_reg, neg_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SUM_W-1:0] mag;
    logic [CNT_W:0]   rem_sh;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        mag       = total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);
        rem_sh    = {rem_reg, dvd_reg[N-1]};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        itr_next  = itr_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = {1'b0, mag} + N'(count >> 1);
            rem_next  = '0;
            dvs_next  = count;
            itr_next  = '0;
            neg_next  = total[SUM_W-1];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = CNT_W'(rem_sh - {1'b0, dvs_reg});
                dvd_next = {dvd_reg[N-2:0], 1'b1};
            end
            else
            begin
                rem_next = CNT_W'(rem_sh);
                dvd_next = {dvd_reg[N-2:0], 1'b0};
            end
            itr_next = ITR_W'(itr_reg + 1'b1);
            if (itr_reg == ITR_W'(N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            itr_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            itr_reg  <= itr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign mean = neg_reg ? -$signed(dvd_reg[15:0]) : $signed(dvd_reg[15:0]);
    assign done = done_reg;
endmodule
`default_nettype wire

// ===== rtl/tilt_angle_moving_average.sv =====
// throughput: one item at a time; the next item is taken once the result is accepted
// the work runs through the bit-serial root, the two cordic units side by side, and
// the mean dividers (one quotient bit per cycle)
// reset: asynchronous, clears the control state, fill count, write slot and totals
`timescale 1ns / 1ps
`default_nettype none
`include "tilt_angle_moving_average_macros.svh"
module tilt_angle_moving_average
    import tam_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    tam_in_if.sink    sample,
    tam_out_if.source result
);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W  = 16 + CNT_W;

    tam_state_t state_reg, state_next;

    // sample registers and squares, loaded at accept
    logic signed [SAMPLE_W-1:0] ax_reg, ay_reg, az_reg;
    logic [SQ_W-1:0]            ysq_reg, zsq_reg;

    // window state: ring memories plus running totals
    logic signed [15:0]         pitch_mem [WINDOW_DEPTH];
    logic signed [15:0]         roll_mem  [WINDOW_DEPTH];
    logic signed [15:0]         pitch_old_reg, roll_old_reg;
    logic [CNT_W-1:0]           fill_reg, fill_next;
    logic [ADDR_W-1:0]          slot_reg, slot_next;
    logic signed [SUM_W-1:0]    pitch_total_reg, pitch_total_next;
    logic signed [SUM_W-1:0]    roll_total_reg, roll_total_next;
    logic                       full;

    // result registers
    logic signed [14:0]         pitch_now_reg, pitch_mean_reg;
    logic signed [15:0]         roll_now_reg, roll_mean_reg;

    // unit handshakes
    logic                       root_start, root_done;
    logic [ROOT_W-1:0]          root;
    logic                       angle_start, pitch_done, roll_done;
    logic signed [15:0]         pitch_angle, roll_angle;
    logic                       div_start, pitch_div_done, roll_div_done;
    logic signed [15:0]         pitch_div_mean, roll_div_mean;
    logic                       accept;

    assign accept = sample.valid && sample.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:        if (sample.valid) state_next = ST_ROOT_GO;
            ST_ROOT_GO:     state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT:   if (root_done) state_next = ST_ANGLE_WAIT;
            ST_ANGLE_WAIT:  if (pitch_done && roll_done) state_next = ST_UPDATE;
            ST_UPDATE:      state_next = ST_DIVIDE_WAIT;
            ST_DIVIDE_WAIT: if (pitch_div_done && roll_div_done) state_next = ST_DONE;
            ST_DONE:        if (result.ready) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        sample.ready = (state_reg == ST_IDLE);
        result.valid = (state_reg == ST_DONE);
        root_start   = (state_reg == ST_ROOT_GO);
        angle_start  = (state_reg == ST_ROOT_WAIT) && root_done;
        div_start    = (state_reg == ST_UPDATE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg  <= sample.accel_x;
            ay_reg  <= sample.accel_y;
            az_reg  <= sample.accel_z;
            ysq_reg <= SQ_W'(sample.accel_y * sample.accel_y);
            zsq_reg <= SQ_W'(sample.accel_z * sample.accel_z);
        end
    end

    // r = floor(sqrt(y*y + z*z))
    tam_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (ysq_reg + zsq_reg),
        .done     (root_done),
        .root     (root)
    );

    // pitch = atan2(-x, r), roll = atan2(y, z), both in parallel
    tam_cordic u_cordic_pitch (
        .clk   (clk),
        .rst_n (rst_n),
        .start (angle_start),
        .num   (-OPND_W'(ax_reg)),
        .den   ($signed({1'b0, root})),
        .limit (PITCH_LIMIT),
        .done  (pitch_done),
        .angle (pitch_angle)
    );

    tam_cordic u_cordic_roll (
        .clk   (clk),
        .rst_n (rst_n),
        .start (angle_start),
        .num   (OPND_W'(ay_reg)),
        .den   (OPND_W'(az_reg)),
        .limit (ROLL_LIMIT),
        .done  (roll_done),
        .angle (roll_angle)
    );

    // ring memories: registered read of the slot about to be overwritten; the slot
    // only moves in ST_UPDATE, so the read is settled before that slot is written
    always_ff @(posedge clk)
    begin
        pitch_old_reg <= pitch_mem[slot_reg];
        roll_old_reg  <= roll_mem[slot_reg];
        if (state_reg == ST_UPDATE)
        begin
            pitch_mem[slot_reg] <= pitch_angle;
            roll_mem[slot_reg]  <= roll_angle;
        end
    end

    // once the ring is full the oldest value leaves the totals; before that the
    // slot was never written and the value read from it is not used
    always_comb
    begin
        full             = (fill_reg == CNT_W'(WINDOW_DEPTH));
        fill_next        = full ? fill_reg : CNT_W'(fill_reg + 1'b1);
        slot_next        = (slot_reg == ADDR_W'(WINDOW_DEPTH - 1)) ? '0
                                                                  : ADDR_W'(slot_reg + 1'b1);
        pitch_total_next = pitch_total_reg + SUM_W'(pitch_angle);
        roll_total_next  = roll_total_reg + SUM_W'(roll_angle);
        if (full)
        begin
            pitch_total_next = pitch_total_next - SUM_W'(pitch_old_reg);
            roll_total_next  = roll_total_next - SUM_W'(roll_old_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            slot_reg        <= '0;
            pitch_total_reg <= '0;
            roll_total_reg  <= '0;
        end
        else if (state_reg == ST_UPDATE)
        begin
            fill_reg        <= fill_next;
            slot_reg        <= slot_next;
            pitch_total_reg <= pitch_total_next;
            roll_total_reg  <= roll_total_next;
        end
    end

    // means over the count that already includes this item
    tam_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div_pitch (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .total (pitch_total_next),
        .count (fill_next),
        .done  (pitch_div_done),
        .mean  (pitch_div_mean)
    );

    tam_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div_roll (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .total (roll_total_next),
        .count (fill_next),
        .done  (roll_div_done),
        .mean  (roll_div_mean)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
        begin
            pitch_now_reg <= pitch_angle[14:0];
            roll_now_reg  <= roll_angle;
        end
        if (state_reg == ST_DIVIDE_WAIT && pitch_div_done)
        begin
            pitch_mean_reg <= pitch_div_mean[14:0];
            roll_mean_reg  <= roll_div_mean;
        end
    end

    assign result.pitch_now  = pitch_now_reg;
    assign result.roll_now   = roll_now_reg;
    assign result.pitch_mean = pitch_mean_reg;
    assign result.roll_mean  = roll_mean_reg;

    `TAM_ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_reg <= CNT_W'(WINDOW_DEPTH))
    `TAM_ASSERT_NEXT(a_accept_starts, accept, state_reg == ST_ROOT_GO)
    `TAM_ASSERT_IMPLIES(a_count_nonzero, state_reg == ST_DIVIDE_WAIT, fill_reg != '0)
    `TAM_ASSERT_IMPLIES(a_units_in_step, state_reg == ST_ANGLE_WAIT, pitch_done == roll_done)
endmodule
`default_nettype wire
